FILE: src/mdio_c22_pkg.sv
// Shared types and constants for the clause 22 MDIO management master.
// Used by mdio_c22_front, mdio_c22_queue, mdio_c22_back and mdio_clause22_master.
package mdio_c22_pkg;

    // request type codes on the input item
    localparam logic [1:0] REQ_COMMAND = 2'd0;
    localparam logic [1:0] REQ_STATUS  = 2'd1;
    localparam logic [1:0] REQ_TICK    = 2'd2;
    localparam logic [1:0] REQ_SPARE   = 2'd3;

    localparam logic [1:0] OP_READ     = 2'd2;

    // frame layout: ST=01, opcode, PHY, REG, TA=10, 16 data bits
    localparam logic [1:0] FRAME_ST    = 2'b01;
    localparam logic [1:0] FRAME_TA    = 2'b10;
    localparam logic [4:0] IDX_LAST    = 5'd31;
    localparam logic [4:0] IDX_TA      = 5'd14;
    localparam logic [4:0] IDX_DATA    = 5'd16;

    localparam logic [5:0] MAX_PREAMBLE   = 6'd32;
    localparam logic [5:0] PREAMBLE_RESET = 6'd32;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        start_toggle;
        logic [1:0]  opcode;
        logic [4:0]  phy_address;
        logic [4:0]  register_address;
        logic [15:0] write_data;
        logic        mdio_in;
    } req_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        busy_res;
        logic        mdio_out;
        logic        mdio_drive_enable;
    } rsp_t;

    typedef enum logic [1:0] {
        KIND_COMMAND,
        KIND_STATUS,
        KIND_TICK
    } kind_t;

    // classified item handed from the front to the back
    typedef struct packed {
        kind_t       kind;
        logic        start_toggle;
        logic        is_read;
        logic [31:0] frame_word;
        logic        mdio_in;
    } op_t;

endpackage

FILE: src/mdio_c22_front.sv
// Front end: accepts request items, classifies them and prebuilds the frame word.
// Depends on mdio_c22_pkg.
module mdio_c22_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mdio_c22_pkg::req_t   s_item,
    output logic                 op_valid,
    input  logic                 op_ready,
    output mdio_c22_pkg::op_t    op_item
);

    logic               vld_reg, vld_next;
    mdio_c22_pkg::op_t  op_reg, op_next;
    logic               rd;

    assign s_ready  = !vld_reg || op_ready;
    assign op_valid = vld_reg;
    assign op_item  = op_reg;

    always_comb begin
        rd = (s_item.opcode == mdio_c22_pkg::OP_READ);
        op_next = op_reg;
        op_next.start_toggle = s_item.start_toggle;
        op_next.is_read      = rd;
        op_next.mdio_in      = s_item.mdio_in;
        op_next.frame_word   = {mdio_c22_pkg::FRAME_ST, s_item.opcode, s_item.phy_address,
                                s_item.register_address, mdio_c22_pkg::FRAME_TA,
                                rd ? 16'h0000 : s_item.write_data};
        unique case (s_item.req_type) inside
            mdio_c22_pkg::REQ_COMMAND:                         op_next.kind = mdio_c22_pkg::KIND_COMMAND;
            mdio_c22_pkg::REQ_TICK:                            op_next.kind = mdio_c22_pkg::KIND_TICK;
            mdio_c22_pkg::REQ_STATUS, mdio_c22_pkg::REQ_SPARE: op_next.kind = mdio_c22_pkg::KIND_STATUS;
            default:                                           op_next.kind = mdio_c22_pkg::KIND_STATUS;
        endcase
        vld_next = vld_reg;
        if (s_valid && s_ready) begin
            vld_next = 1'b1;
        end else if (op_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg <= op_next;
        end
    end

endmodule

FILE: src/mdio_c22_queue.sv
// Two-entry queue between the classifying front and the executing back.
// Depends on mdio_c22_pkg.
module mdio_c22_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mdio_c22_pkg::op_t    in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mdio_c22_pkg::op_t    out_item
);

    mdio_c22_pkg::op_t  mem [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;
    logic               push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: src/mdio_c22_back.sv
// Back end: runs the frame sequencer and registers the result, one item per cycle
// while m_ready does not stall it. Depends on mdio_c22_pkg.
module mdio_c22_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [5:0]           cfg_data,
    input  logic                 op_valid,
    output logic                 op_ready,
    input  mdio_c22_pkg::op_t    op_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mdio_c22_pkg::rsp_t   m_item
);

    logic [5:0]         preamble_reg, preamble_next;
    logic               last_start_reg, last_start_next;
    logic               busy_reg, busy_next;
    logic [6:0]         pos_reg, pos_next;
    logic [31:0]        shift_reg, shift_next;
    logic               is_read_reg, is_read_next;
    logic [15:0]        captured_reg, captured_next;
    logic               out_vld_reg, out_vld_next;
    mdio_c22_pkg::rsp_t out_reg, out_next;

    logic [5:0]         eff_pre;
    logic [6:0]         diff;
    logic [4:0]         idx;
    logic [4:0]         sh;
    logic               level, drive;
    logic               go;

    assign op_ready = !out_vld_reg || m_ready;
    assign go       = op_valid && op_ready;
    assign m_valid  = out_vld_reg;
    assign m_item   = out_reg;

    always_comb begin
        eff_pre = (preamble_reg > mdio_c22_pkg::MAX_PREAMBLE) ? mdio_c22_pkg::MAX_PREAMBLE
                                                              : preamble_reg;
        diff = pos_reg - {1'b0, eff_pre};
        idx  = (diff > {2'b00, mdio_c22_pkg::IDX_LAST}) ? mdio_c22_pkg::IDX_LAST : diff[4:0];
        sh   = ~idx;

        preamble_next   = cfg_valid ? cfg_data : preamble_reg;
        last_start_next = last_start_reg;
        busy_next       = busy_reg;
        pos_next        = pos_reg;
        shift_next      = shift_reg;
        is_read_next    = is_read_reg;
        captured_next   = captured_reg;
        level           = 1'b1;
        drive           = 1'b0;

        unique case (op_item.kind)
            mdio_c22_pkg::KIND_COMMAND: begin
                if (!busy_reg && (op_item.start_toggle != last_start_reg)) begin
                    last_start_next = op_item.start_toggle;
                    is_read_next    = op_item.is_read;
                    shift_next      = op_item.frame_word;
                    pos_next        = 7'd0;
                    busy_next       = 1'b1;
                end
            end
            mdio_c22_pkg::KIND_TICK: begin
                if (busy_reg) begin
                    if (pos_reg < {1'b0, eff_pre}) begin
                        drive    = 1'b1;
                        pos_next = pos_reg + 7'd1;
                    end else begin
                        if (is_read_reg && (idx >= mdio_c22_pkg::IDX_TA)) begin
                            // line released; sample data bits into the frame word
                            if (idx >= mdio_c22_pkg::IDX_DATA) begin
                                shift_next[sh] = op_item.mdio_in;
                            end
                        end else begin
                            level = shift_reg[sh];
                            drive = 1'b1;
                        end
                        if (idx == mdio_c22_pkg::IDX_LAST) begin
                            if (is_read_reg) begin
                                captured_next = shift_next[15:0];
                            end
                            busy_next = 1'b0;
                            pos_next  = 7'd0;
                        end else begin
                            pos_next = pos_reg + 7'd1;
                        end
                    end
                end
            end
            mdio_c22_pkg::KIND_STATUS: begin
            end
            default: begin
            end
        endcase

        out_next.read_data         = captured_next;
        out_next.busy_res          = busy_next;
        out_next.mdio_out          = level;
        out_next.mdio_drive_enable = drive;

        out_vld_next = out_vld_reg;
        if (go) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preamble_reg   <= mdio_c22_pkg::PREAMBLE_RESET;
            last_start_reg <= 1'b0;
            busy_reg       <= 1'b0;
            pos_reg        <= 7'd0;
            shift_reg      <= 32'd0;
            is_read_reg    <= 1'b0;
            captured_reg   <= 16'd0;
            out_vld_reg    <= 1'b0;
        end else begin
            preamble_reg <= preamble_next;
            out_vld_reg  <= out_vld_next;
            if (go) begin
                last_start_reg <= last_start_next;
                busy_reg       <= busy_next;
                pos_reg        <= pos_next;
                shift_reg      <= shift_next;
                is_read_reg    <= is_read_next;
                captured_reg   <= captured_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            out_reg <= out_next;
        end
    end

endmodule

FILE: src/mdio_clause22_master.sv
// Top level of the clause 22 MDIO management master.
// Depends on mdio_c22_pkg, mdio_c22_front, mdio_c22_queue and mdio_c22_back.
//
// Usage:
//   s_valid/s_ready/s_item carry request items: command writes, status reads
//   and MDC bit ticks. Every request yields exactly one result item on
//   m_valid/m_ready/m_item with the captured read data, busy flag and the MDIO
//   level and drive enable for that tick (idle level 1, released otherwise).
//   cfg_valid/cfg_ready/cfg_data write the preamble length; cfg_ready is
//   always high. Write it only while no request is outstanding.
// Timing:
//   A request passes the front register, the two-entry queue and the result
//   register of the back end, which drives m_valid and m_item. One item per
//   cycle is sustained while m_ready stays high; each request is one step of
//   the frame sequencer in the back end.
// Reset (aresetn low, synchronous) empties all stages, clears the frame
// state and read data, and sets the preamble length to 32.
// Stall: when m_ready is low the result register holds; the queue and front
// register keep accepting until they fill, then s_ready drops.
module mdio_clause22_master (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [5:0]           cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mdio_c22_pkg::req_t   s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mdio_c22_pkg::rsp_t   m_item
);

    logic               fq_valid, fq_ready;
    mdio_c22_pkg::op_t  fq_item;
    logic               qb_valid, qb_ready;
    mdio_c22_pkg::op_t  qb_item;

    // configuration is taken in any cycle
    assign cfg_ready = 1'b1;

    // classify requests and prebuild frame words
    mdio_c22_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .op_valid (fq_valid),
        .op_ready (fq_ready),
        .op_item  (fq_item)
    );

    // decouple front and back so each can stall on its own
    mdio_c22_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    // advance the frame sequencer and register the result
    mdio_c22_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .op_valid  (qb_valid),
        .op_ready  (qb_ready),
        .op_item   (qb_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule
